>>> rtl/cap_pkg.sv
// Shared types, constants and helper functions for the candidate address/port parser.
// No dependencies; imported by every module of the block.
package cap_pkg;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [3:0] PREFIX_LEN    = 4'd10;
    localparam logic [5:0] ADDR_MAX      = 6'd45;
    localparam logic [5:0] ADDR_SAT      = 6'd46;
    localparam logic [15:0] OCTET_MAX    = 16'd255;
    localparam logic [2:0] FIELD_OF_ADDR = 3'd5;
    localparam logic [2:0] OCTET_COUNT   = 3'd4;

    typedef enum logic [2:0] {
        PH_SKIP_FIELD = 3'd0,
        PH_SKIP_RUN   = 3'd1,
        PH_ADDRESS    = 3'd2,
        PH_GAP        = 3'd3,
        PH_PORT       = 3'd4,
        PH_DONE       = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PARSE   = 2'd1,
        ST_NOTIMPL = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] ipv4_address;
        logic [15:0] port_number;
    } t_result;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0: ch = 8'h63;
            4'd1: ch = 8'h61;
            4'd2: ch = 8'h6e;
            4'd3: ch = 8'h64;
            4'd4: ch = 8'h69;
            4'd5: ch = 8'h64;
            4'd6: ch = 8'h61;
            4'd7: ch = 8'h74;
            4'd8: ch = 8'h65;
            4'd9: ch = 8'h3a;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    endfunction

    // Multiply by ten and add one decimal digit, modulo 65536.
    function automatic logic [15:0] mul10_add(input logic [15:0] v, input logic [7:0] ch);
        return {v[12:0], 3'b000} + {v[14:0], 1'b0} + {12'd0, ch[3:0]};
    endfunction

endpackage

>>> rtl/cap_in_stage.sv
// Input register of the parser: holds one text byte beat until the parser takes it.
// Depends on cap_pkg.
module cap_in_stage
    import cap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_out_space,
    output logic       o_in_ready,
    output logic       o_step,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    // A line end needs room in the result register; other bytes always proceed.
    assign o_step     = r_valid && ((r_byte != CHAR_NUL) || i_out_space);
    assign o_in_ready = !r_valid || o_step;
    assign o_byte     = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (i_in_valid && o_in_ready) begin
            n_valid = 1'b1;
        end else if (o_step) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_text_byte;
        end
    end

`ifndef SYNTHESIS
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_step |=> r_valid && $stable(r_byte))
        else $error("held input beat changed while stalled");
`endif

endmodule

>>> rtl/cap_parser.sv
// Per-byte parse state and line-end result computation for the candidate line.
// Depends on cap_pkg.
module cap_parser
    import cap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_result
);

    logic [3:0]  r_pcnt,   n_pcnt;
    t_phase      r_phase,  n_phase;
    logic [2:0]  r_field,  n_field;
    logic [5:0]  r_len,    n_len;
    logic [2:0]  r_idx,    n_idx;
    logic [15:0] r_val,    n_val;
    logic [31:0] r_oct,    n_oct;
    logic [15:0] r_port,   n_port;
    t_status     r_err,    n_err;

    logic        do_addr;
    logic        do_close;
    logic        is_space;
    t_status     cl_err;
    logic [2:0]  cl_idx;
    logic [31:0] cl_oct;
    t_status     status;

    assign is_space = (i_byte == CHAR_SPACE);

    // Outcome of closing the current octet, taken from the present state.
    always_comb begin
        cl_err = r_err;
        cl_idx = r_idx;
        cl_oct = r_oct;
        if (r_err == ST_OK) begin
            if ((r_idx >= OCTET_COUNT) || (r_val > OCTET_MAX)) begin
                cl_err = ST_PARSE;
            end else begin
                cl_oct = {r_oct[23:0], r_val[7:0]};
                cl_idx = r_idx + 3'd1;
            end
        end
    end

    always_comb begin
        status = ST_OK;
        if (r_phase == PH_ADDRESS) begin
            if ((r_len == 6'd0) || (r_len > ADDR_MAX) || (r_port == 16'd0)) begin
                status = ST_PARSE;
            end else if (cl_err != ST_OK) begin
                status = cl_err;
            end else if (cl_idx != OCTET_COUNT) begin
                status = ST_PARSE;
            end
        end else begin
            if ((r_len == 6'd0) || (r_len > ADDR_MAX) || (r_port == 16'd0)) begin
                status = ST_PARSE;
            end else if (r_err != ST_OK) begin
                status = r_err;
            end else if (r_idx != OCTET_COUNT) begin
                status = ST_PARSE;
            end
        end
    end

    always_comb begin
        n_pcnt   = r_pcnt;
        n_phase  = r_phase;
        n_field  = r_field;
        n_len    = r_len;
        n_idx    = r_idx;
        n_val    = r_val;
        n_oct    = r_oct;
        n_port   = r_port;
        n_err    = r_err;
        do_addr  = 1'b0;
        do_close = 1'b0;
        if (i_step && (i_byte != CHAR_NUL)) begin
            case (r_phase)
                PH_SKIP_FIELD: begin
                    if (is_space) begin
                        n_field = r_field + 3'd1;
                        n_phase = PH_SKIP_RUN;
                    end
                end
                PH_SKIP_RUN: begin
                    if (!is_space) begin
                        if (r_field >= FIELD_OF_ADDR) begin
                            n_phase = PH_ADDRESS;
                            do_addr = 1'b1;
                        end else begin
                            n_phase = PH_SKIP_FIELD;
                        end
                    end
                end
                PH_ADDRESS: begin
                    if (is_space) begin
                        do_close = 1'b1;
                        n_phase  = PH_GAP;
                    end else begin
                        do_addr = 1'b1;
                    end
                end
                PH_GAP, PH_PORT: begin
                    if (!(is_space && (r_phase == PH_GAP))) begin
                        if (is_digit(i_byte)) begin
                            n_port  = mul10_add(r_port, i_byte);
                            n_phase = PH_PORT;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (do_addr) begin
                if (r_len < ADDR_SAT) begin
                    n_len = r_len + 6'd1;
                end
                if (r_err == ST_OK) begin
                    if (i_byte == CHAR_DOT) begin
                        do_close = 1'b1;
                    end else if (is_digit(i_byte)) begin
                        n_val = mul10_add(r_val, i_byte);
                    end else begin
                        n_err = ST_NOTIMPL;
                    end
                end
            end

            if (do_close && (r_err == ST_OK)) begin
                n_err = cl_err;
                n_idx = cl_idx;
                n_oct = cl_oct;
                if (cl_err == ST_OK) begin
                    n_val = 16'd0;
                end
            end

            // A completed prefix restarts the parse in the candidate form.
            if (r_pcnt < PREFIX_LEN) begin
                if (i_byte == prefix_char(r_pcnt)) begin
                    n_pcnt = r_pcnt + 4'd1;
                    if (r_pcnt == PREFIX_LEN - 4'd1) begin
                        n_phase = PH_SKIP_FIELD;
                        n_field = 3'd1;
                        n_len   = 6'd0;
                        n_idx   = 3'd0;
                        n_val   = 16'd0;
                        n_oct   = 32'd0;
                        n_port  = 16'd0;
                        n_err   = ST_OK;
                    end
                end else begin
                    n_pcnt = PREFIX_LEN;
                end
            end
        end else if (i_step) begin
            n_pcnt  = 4'd0;
            n_phase = PH_ADDRESS;
            n_field = 3'd1;
            n_len   = 6'd0;
            n_idx   = 3'd0;
            n_val   = 16'd0;
            n_oct   = 32'd0;
            n_port  = 16'd0;
            n_err   = ST_OK;
        end
    end

    assign o_res_valid           = i_step && (i_byte == CHAR_NUL);
    assign o_result.status       = status;
    assign o_result.ipv4_address = (status == ST_OK)
                                   ? ((r_phase == PH_ADDRESS) ? cl_oct : r_oct) : 32'd0;
    assign o_result.port_number  = (status == ST_OK) ? r_port : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt  <= 4'd0;
            r_phase <= PH_ADDRESS;
            r_field <= 3'd1;
            r_len   <= 6'd0;
            r_idx   <= 3'd0;
            r_val   <= 16'd0;
            r_oct   <= 32'd0;
            r_port  <= 16'd0;
            r_err   <= ST_OK;
        end else begin
            r_pcnt  <= n_pcnt;
            r_phase <= n_phase;
            r_field <= n_field;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_val   <= n_val;
            r_oct   <= n_oct;
            r_port  <= n_port;
            r_err   <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_ADDRESS) && (r_pcnt == 4'd0) && (r_len == 6'd0))
        else $error("parse state not cleared after line end");
    a_octet_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= OCTET_COUNT)
        else $error("octet index beyond four");
`endif

endmodule

>>> rtl/cap_out_stage.sv
// Result register of the parser: holds one result beat until the consumer takes it.
// Depends on cap_pkg.
module cap_out_stage
    import cap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    input  t_result     i_result,
    input  logic        i_out_ready,
    output logic        o_space,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_ipv4_address,
    output logic [15:0] o_port_number
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_space        = !r_valid || i_out_ready;
    assign o_out_valid    = r_valid;
    assign o_status       = r_result.status;
    assign o_ipv4_address = r_result.ipv4_address;
    assign o_port_number  = r_result.port_number;

    always_comb begin
        n_valid = r_valid;
        if (i_res_valid) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_result <= i_result;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> o_space)
        else $error("result beat overwritten before it was taken");
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_result.status != ST_OK) |->
            (r_result.ipv4_address == 32'd0) && (r_result.port_number == 16'd0))
        else $error("address or port not zero on an error result");
`endif

endmodule

>>> rtl/candidate_address_port_parser_top.sv
// A line's zero byte is held in the input register; its result is then registered at the output.
// Throughput: one byte beat per cycle; only a line end waits, and only while a result is unclaimed.
// Reset: synchronous, active low; clears the parse state and both holding registers' valid flags.
// Top level of the candidate address/port parser: input register, parser, result register.
// Depends on cap_pkg, cap_in_stage, cap_parser and cap_out_stage.
module candidate_address_port_parser_top
    import cap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_ipv4_address,
    output logic [15:0] o_port_number
);

    logic       out_space;
    logic       step;
    logic [7:0] step_byte;
    logic       res_valid;
    t_result    result;

    cap_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_text_byte (i_text_byte),
        .i_out_space (out_space),
        .o_in_ready  (o_in_ready),
        .o_step      (step),
        .o_byte      (step_byte)
    );

    cap_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (step_byte),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    cap_out_stage u_out_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res_valid    (res_valid),
        .i_result       (result),
        .i_out_ready    (i_out_ready),
        .o_space        (out_space),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_ipv4_address (o_ipv4_address),
        .o_port_number  (o_port_number)
    );

`ifndef SYNTHESIS
    a_line_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (step_byte == CHAR_NUL) |=> o_out_valid)
        else $error("line end did not produce a result beat");
    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("unclaimed result beat dropped or changed");
    a_byte_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");
`endif

endmodule

>>> test/candidate_address_port_parser_top_tb.sv
// Testbench for candidate_address_port_parser_top: drives text lines byte by byte and checks
// each line's status, address and port against a decoder kept inside the scoreboard class.
// Depends on cap_pkg and the parser RTL; stands alone otherwise.
module candidate_address_port_parser_top_tb;
    import cap_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int BYTE_TARGET = 1200;

    class endpoint_decoder;
        t_result     decoded_endpoints[$];
        int          mismatches;
        string       lead = "candidate:";
        logic [3:0]  match_cnt;
        logic        cand_mode;
        t_phase      phase;
        logic [2:0]  fields;
        logic [5:0]  addr_count;
        logic [2:0]  oct_idx;
        logic [15:0] oct_val;
        logic [31:0] octets;
        logic [15:0] port_acc;
        t_status     addr_err;

        function new();
            mismatches = 0;
            clear_all();
        endfunction

        function void restart(t_phase p);
            phase      = p;
            fields     = 3'd1;
            addr_count = 6'd0;
            oct_idx    = 3'd0;
            oct_val    = 16'd0;
            octets     = 32'd0;
            port_acc   = 16'd0;
            addr_err   = ST_OK;
        endfunction

        function void clear_all();
            match_cnt = 4'd0;
            cand_mode = 1'b0;
            restart(PH_ADDRESS);
        endfunction

        function logic decimal(logic [7:0] c);
            return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        endfunction

        function logic [15:0] times_ten_plus(logic [15:0] v, logic [7:0] c);
            return v * 16'd10 + {8'd0, c - CHAR_ZERO};
        endfunction

        function void end_octet();
            if (addr_err != ST_OK) return;
            if (oct_idx >= OCTET_COUNT || oct_val > OCTET_MAX) begin
                addr_err = ST_PARSE;
                return;
            end
            octets  = {octets[23:0], oct_val[7:0]};
            oct_idx = oct_idx + 3'd1;
            oct_val = 16'd0;
        endfunction

        function void address_char(logic [7:0] c);
            if (addr_count < ADDR_SAT) addr_count = addr_count + 6'd1;
            if (addr_err != ST_OK) return;
            if (c == CHAR_DOT) begin
                end_octet();
            end else if (decimal(c)) begin
                oct_val = times_ten_plus(oct_val, c);
            end else begin
                addr_err = ST_NOTIMPL;
            end
        endfunction

        function void parse_char(logic [7:0] c);
            case (phase)
                PH_SKIP_FIELD: begin
                    if (c == CHAR_SPACE) begin
                        fields = fields + 3'd1;
                        phase  = PH_SKIP_RUN;
                    end
                end
                PH_SKIP_RUN: begin
                    if (c != CHAR_SPACE) begin
                        if (fields >= FIELD_OF_ADDR) begin
                            phase = PH_ADDRESS;
                            address_char(c);
                        end else begin
                            phase = PH_SKIP_FIELD;
                        end
                    end
                end
                PH_ADDRESS: begin
                    if (c == CHAR_SPACE) begin
                        end_octet();
                        phase = PH_GAP;
                    end else begin
                        address_char(c);
                    end
                end
                PH_GAP, PH_PORT: begin
                    if (!(c == CHAR_SPACE && phase == PH_GAP)) begin
                        if (decimal(c)) begin
                            port_acc = times_ten_plus(port_acc, c);
                            phase    = PH_PORT;
                        end else begin
                            phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void take_char(logic [7:0] c);
            t_result r;
            t_status st;
            if (c != CHAR_NUL) begin
                parse_char(c);
                if (match_cnt < PREFIX_LEN) begin
                    if (c == lead[match_cnt]) begin
                        match_cnt = match_cnt + 4'd1;
                        if (match_cnt == PREFIX_LEN) begin
                            cand_mode = 1'b1;
                            restart(PH_SKIP_FIELD);
                        end
                    end else begin
                        match_cnt = PREFIX_LEN;
                    end
                end
                return;
            end
            if (phase == PH_ADDRESS) end_octet();
            if (addr_count == 6'd0 || addr_count > ADDR_MAX || port_acc == 16'd0) begin
                st = ST_PARSE;
            end else if (addr_err != ST_OK) begin
                st = addr_err;
            end else if (oct_idx != OCTET_COUNT) begin
                st = ST_PARSE;
            end else begin
                st = ST_OK;
            end
            r.status       = st;
            r.ipv4_address = (st == ST_OK) ? octets : 32'd0;
            r.port_number  = (st == ST_OK) ? port_acc : 16'd0;
            decoded_endpoints.push_back(r);
            clear_all();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task compare_endpoint(logic [1:0] status, logic [31:0] addr, logic [15:0] port);
            t_result e;
            if (decoded_endpoints.size() == 0) begin
                report($sformatf("result beat with no line pending, status %0d", status));
                return;
            end
            e = decoded_endpoints.pop_front();
            if (status !== e.status)
                report($sformatf("status %0d, wanted %0d", status, e.status));
            if (addr !== e.ipv4_address)
                report($sformatf("address %h, wanted %h", addr, e.ipv4_address));
            if (port !== e.port_number)
                report($sformatf("port %0d, wanted %0d", port, e.port_number));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_text_byte = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [31:0] o_ipv4_address;
    logic [15:0] o_port_number;

    endpoint_decoder decoder;
    logic [7:0]      line_bytes[$];
    int              bytes_sent = 0;
    int              stall_cycles = 0;
    logic            quiet = 1'b0;

    candidate_address_port_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_ipv4_address (o_ipv4_address),
        .o_port_number  (o_port_number)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            decoder.take_char(i_text_byte);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            decoder.compare_endpoint(o_status, o_ipv4_address, o_port_number);
        end
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    task send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        quiet <= (bytes_sent >= 500) && (bytes_sent < 800);
    endtask

    task push_char(input logic [7:0] c);
        line_bytes.push_back(c);
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    task push_dec(input int unsigned v);
        push_text($sformatf("%0d", v));
    endtask

    task push_spaces(input int n);
        repeat (n) push_char(CHAR_SPACE);
    endtask

    // Terminates the line held in line_bytes and sends it.
    task send_line();
        push_char(CHAR_NUL);
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
        line_bytes.delete();
    endtask

    task add_address();
        int count;
        int zeros;
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
        for (int i = 0; i < count; i++) begin
            if (i != 0) push_char(CHAR_DOT);
            if ($urandom_range(0, 29) != 0) begin
                zeros = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : 0;
                repeat (zeros) push_char(CHAR_ZERO);
                if ($urandom_range(0, 11) == 0) begin
                    push_dec($urandom_range(256, 99999));
                end else begin
                    push_dec($urandom_range(0, 255));
                end
                if ($urandom_range(0, 24) == 0) push_char(8'($urandom_range(33, 126)));
            end
        end
    endtask

    task add_port_and_tail();
        int pick;
        push_spaces($urandom_range(1, 3));
        pick = $urandom_range(0, 19);
        if (pick == 1) begin
            push_dec(0);
        end else if (pick == 2) begin
            push_dec($urandom_range(65536, 999999));
        end else if (pick != 0) begin
            push_dec($urandom_range(1, 65535));
        end
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            push_text(" typ host");
        end else if (pick == 1) begin
            repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(1, 255)));
        end
    endtask

    task add_random_line();
        int pick;
        int nfields;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            push_text("candidate:");
            nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
            for (int i = 0; i < nfields; i++) begin
                if (i == 2) begin
                    push_text($urandom_range(0, 1) ? "udp" : "tcp");
                end else begin
                    push_dec($urandom());
                end
                push_spaces($urandom_range(1, 2));
            end
            add_address();
            add_port_and_tail();
        end else if (pick < 80) begin
            add_address();
            add_port_and_tail();
        end else if (pick < 90) begin
            push_text(decoder.lead.substr(0, $urandom_range(0, 8)));
            if ($urandom_range(0, 1)) push_char(8'($urandom_range(1, 255)));
            add_address();
            add_port_and_tail();
        end else begin
            repeat ($urandom_range(1, 30)) push_char(8'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        decoder = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_text("255.255.255.255 65535");                       send_line();
        push_text("0.0.0.0 1");                                   send_line();
        send_line();
        push_text("1.2.3.4 0");                                   send_line();
        push_text("candidate:1 1 udp 2122260223 192.168.1.20 54400 typ host");
        send_line();
        push_text("1.2.3 80");                                    send_line();
        push_text("1.2.3.256 80");                                send_line();
        push_text("::1 80");                                      send_line();
        push_text("1.2.x.300 80");                                send_line();
        push_text("1.2.300.x 80");                                send_line();
        push_text("1.2.3.4.5 80");                                send_line();
        push_text("0000000000000000000000000000000000000001.2.3.4 80");
        send_line();
        push_text("candidXYZ 80");                                send_line();
        push_text("candidate 1.2.3.4 80");                        send_line();
        push_text("candidate:a b c");                             send_line();
        push_text("10.0.0.1   8080 trailing 77");                 send_line();
        push_text("10.0.0.1 99999");                              send_line();
        push_char(8'hff);
        push_char(8'h80);
        push_text(" 7");                                          send_line();

        while (bytes_sent < BYTE_TARGET) begin
            add_random_line();
            send_line();
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (decoder.decoded_endpoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoder.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/cap_pkg.sv
rtl/cap_in_stage.sv
rtl/cap_parser.sv
rtl/cap_out_stage.sv
rtl/candidate_address_port_parser_top.sv
test/candidate_address_port_parser_top_tb.sv
